// File: rtl/ctl_pkg.sv
// Shared types and constants for the cohesive traction law block.
// No dependencies; imported by every module of the block.
package ctl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int MAG_W      = WORD_BITS + 1;
    localparam int CFG_W      = 31;
    localparam int ONSET_W    = 17;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_LAT    = DIV_NUM_W;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int SQRT_REM_W = 34;
    localparam int SQRT_LAT   = SQRT_OUT_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam logic [ONSET_W-1:0] ONE_Q = ONSET_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_CRIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TANGENT_CRIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_ONSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINE_ONSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_OPEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_STIFFNESS = 3'd6;

    localparam logic [1:0] STAT_PRECRIT  = 2'd0;
    localparam logic [1:0] STAT_CRITICAL = 2'd1;
    localparam logic [1:0] STAT_FAILED   = 2'd2;

    typedef enum logic [1:0] {
        REG_RISE,
        REG_PLATEAU,
        REG_FALL,
        REG_ZERO
    } ctl_region_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] jump_tangential;
        logic signed [WORD_BITS-1:0] jump_normal;
    } ctl_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] traction_tangential;
        logic signed [WORD_BITS-1:0] traction_normal;
        logic [CFG_W-1:0]            opening_lambda;
        logic [1:0]                  surface_status;
    } ctl_out_t;

    // effective settings: critical openings nonzero, failure opening at least one
    typedef struct packed {
        logic [CFG_W-1:0]   peak_stress;
        logic [CFG_W-1:0]   dn;
        logic [CFG_W-1:0]   dt;
        logic [ONSET_W-1:0] l1;
        logic [ONSET_W-1:0] l2;
        logic [CFG_W-1:0]   fail;
        logic [CFG_W-1:0]   stiff;
    } ctl_cfg_t;

    typedef struct packed {
        logic                  neg_t;
        logic                  neg_n;
        logic [MAG_W-1:0]      mag_n;
        logic [WORD_BITS-1:0]  r_t;
        logic [WORD_BITS-1:0]  r_n;
        logic [SQRT_OUT_W-1:0] lam;
        ctl_region_t           region;
        logic [1:0]            status;
    } ctl_item_t;

endpackage

// File: rtl/ctl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ctl_pkg for widths; one transfer per cycle.
module ctl_div (
    input  logic                          clk,
    input  logic [ctl_pkg::DIV_NUM_W-1:0] num,
    input  logic [ctl_pkg::DIV_DEN_W-1:0] den,
    output logic [ctl_pkg::DIV_NUM_W-1:0] quo
);
    import ctl_pkg::*;

    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] word;
        logic [DIV_DEN_W-1:0] den;
    } div_stage_t;

    div_stage_t stage_reg  [DIV_LAT];
    div_stage_t stage_next [DIV_LAT];

    function automatic div_stage_t div_step(input div_stage_t s);
        logic [DIV_DEN_W:0] sh;
        logic [DIV_DEN_W:0] diff;
        div_stage_t         r;
        sh   = {s.rem, s.word[DIV_NUM_W-1]};
        diff = sh - {1'b0, s.den};
        r.den = s.den;
        if (sh >= {1'b0, s.den})
        begin
            r.rem  = diff[DIV_DEN_W-1:0];
            r.word = {s.word[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = sh[DIV_DEN_W-1:0];
            r.word = {s.word[DIV_NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        stage_next[0] = div_step('{rem: '0, word: num, den: den});
        for (int s = 1; s < DIV_LAT; s++)
        begin
            stage_next[s] = div_step(stage_reg[s-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_LAT; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    assign quo = stage_reg[DIV_LAT-1].word;

endmodule

// File: rtl/ctl_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on ctl_pkg for widths.
module ctl_sqrt (
    input  logic                           clk,
    input  logic [ctl_pkg::SQRT_IN_W-1:0]  rad,
    output logic [ctl_pkg::SQRT_OUT_W-1:0] root
);
    import ctl_pkg::*;

    typedef struct packed {
        logic [SQRT_REM_W-1:0] rem;
        logic [SQRT_OUT_W-1:0] root;
        logic [SQRT_IN_W-1:0]  rad;
    } sq_stage_t;

    sq_stage_t stage_reg  [SQRT_LAT];
    sq_stage_t stage_next [SQRT_LAT];

    function automatic sq_stage_t sq_step(input sq_stage_t s);
        logic [SQRT_REM_W+1:0] sh;
        logic [SQRT_REM_W+1:0] trial;
        logic [SQRT_REM_W+1:0] diff;
        sq_stage_t             r;
        sh    = {s.rem, s.rad[SQRT_IN_W-1 -: 2]};
        trial = (SQRT_REM_W+2)'({s.root, 2'b01});
        diff  = sh - trial;
        r.rad = s.rad << 2;
        if (sh >= trial)
        begin
            r.rem  = diff[SQRT_REM_W-1:0];
            r.root = {s.root[SQRT_OUT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = sh[SQRT_REM_W-1:0];
            r.root = {s.root[SQRT_OUT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        stage_next[0] = sq_step('{rem: '0, root: '0, rad: rad});
        for (int s = 1; s < SQRT_LAT; s++)
        begin
            stage_next[s] = sq_step(stage_reg[s-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_LAT; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    assign root = stage_reg[SQRT_LAT-1].root;

endmodule

// File: rtl/ctl_fifo.sv
// Short queue between the classifying front end and the traction back end.
// Depends on ctl_pkg for the item type and depth.
module ctl_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ctl_pkg::ctl_item_t din,
    input  logic               pop,
    output logic               valid,
    output ctl_pkg::ctl_item_t dout
);
    import ctl_pkg::*;

    ctl_item_t             entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  full;
    logic                  do_push;
    logic                  do_pop;

    assign valid   = (count_reg != '0);
    assign full    = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign do_pop  = pop && valid;
    assign do_push = push && (!full || do_pop);
    assign dout    = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: rtl/ctl_front.sv
// Front end: takes jump vectors, scales them, forms lambda and classifies
// the traction region and status. Depends on ctl_pkg, ctl_div, ctl_sqrt.
module ctl_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ctl_pkg::ctl_in_t   jump,
    input  ctl_pkg::ctl_cfg_t  cfg,
    output logic               push,
    output ctl_pkg::ctl_item_t item
);
    import ctl_pkg::*;

    localparam logic [DIV_NUM_W-1:0] R_CLIP = DIV_NUM_W'(1) << (WORD_BITS-1);

    typedef struct packed {
        logic                 neg_t;
        logic                 neg_n;
        logic [MAG_W-1:0]     mag_n;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic [WORD_BITS-1:0] r_t;
        logic [WORD_BITS-1:0] r_n;
    } ratio_t;

    function automatic logic [WORD_BITS-1:0] clip_ratio(input logic [DIV_NUM_W-1:0] q);
        return (q > R_CLIP) ? R_CLIP[WORD_BITS-1:0] : q[WORD_BITS-1:0];
    endfunction

    // most negative input maps to 2^32
    function automatic logic [MAG_W-1:0] magnitude(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] neg_v;
        neg_v = ~v + 1'b1;
        if (!v[WORD_BITS-1])
        begin
            return MAG_W'(v);
        end
        if (v[WORD_BITS-2:0] == '0)
        begin
            return MAG_W'(1) << WORD_BITS;
        end
        return MAG_W'(neg_v);
    endfunction

    logic [WORD_BITS-1:0]  raw_t;
    logic [WORD_BITS-1:0]  raw_n;
    logic                  a_valid_reg;
    side_t                 a_side_reg;
    logic [MAG_W-1:0]      a_mag_t_reg;
    logic [DIV_NUM_W-1:0]  quo_t;
    logic [DIV_NUM_W-1:0]  quo_n;
    logic [DIV_LAT-1:0]    dv_reg;
    side_t                 ds_reg [DIV_LAT];
    logic                  b_valid_reg;
    ratio_t                b_ratio_reg;
    logic                  c_valid_reg;
    ratio_t                c_ratio_reg;
    logic [SQRT_IN_W-1:0]  c_sq_t_reg;
    logic [SQRT_IN_W-1:0]  c_sq_n_reg;
    logic                  d_valid_reg;
    ratio_t                d_ratio_reg;
    logic [SQRT_IN_W-1:0]  d_sum_reg;
    logic [SQRT_OUT_W-1:0] lam;
    logic [SQRT_LAT-1:0]   sv_reg;
    ratio_t                ss_reg [SQRT_LAT];
    ratio_t                s_out;
    ctl_region_t           region;
    logic [1:0]            status;

    assign raw_t = jump.jump_tangential;
    assign raw_n = jump.jump_normal;

    ctl_div u_div_t (
        .clk (clk),
        .num (DIV_NUM_W'(a_mag_t_reg) << FRAC_BITS),
        .den (DIV_DEN_W'(cfg.dt)),
        .quo (quo_t)
    );

    ctl_div u_div_n (
        .clk (clk),
        .num (DIV_NUM_W'(a_side_reg.mag_n) << FRAC_BITS),
        .den (DIV_DEN_W'(cfg.dn)),
        .quo (quo_n)
    );

    ctl_sqrt u_sqrt (
        .clk  (clk),
        .rad  (d_sum_reg),
        .root (lam)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            dv_reg      <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            sv_reg      <= '0;
        end
        else
        begin
            a_valid_reg <= accept;
            dv_reg      <= {dv_reg[DIV_LAT-2:0], a_valid_reg};
            b_valid_reg <= dv_reg[DIV_LAT-1];
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            sv_reg      <= {sv_reg[SQRT_LAT-2:0], d_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.neg_t <= raw_t[WORD_BITS-1];
        a_side_reg.neg_n <= raw_n[WORD_BITS-1];
        a_side_reg.mag_n <= magnitude(raw_n);
        a_mag_t_reg      <= magnitude(raw_t);

        ds_reg[0] <= a_side_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            ds_reg[k] <= ds_reg[k-1];
        end

        b_ratio_reg.side <= ds_reg[DIV_LAT-1];
        b_ratio_reg.r_t  <= clip_ratio(quo_t);
        b_ratio_reg.r_n  <= clip_ratio(quo_n);

        c_ratio_reg <= b_ratio_reg;
        c_sq_t_reg  <= SQRT_IN_W'(b_ratio_reg.r_t) * SQRT_IN_W'(b_ratio_reg.r_t);
        c_sq_n_reg  <= SQRT_IN_W'(b_ratio_reg.r_n) * SQRT_IN_W'(b_ratio_reg.r_n);

        d_ratio_reg <= c_ratio_reg;
        d_sum_reg   <= c_sq_t_reg + c_sq_n_reg;

        ss_reg[0] <= d_ratio_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            ss_reg[k] <= ss_reg[k-1];
        end
    end

    assign s_out = ss_reg[SQRT_LAT-1];

    always_comb
    begin
        priority if (lam < SQRT_OUT_W'(cfg.l1))
        begin
            region = REG_RISE;
        end
        else if (lam < SQRT_OUT_W'(cfg.l2))
        begin
            region = (lam == '0) ? REG_ZERO : REG_PLATEAU;
        end
        else if (lam < SQRT_OUT_W'(ONE_Q))
        begin
            region = (lam == '0) ? REG_ZERO : REG_FALL;
        end
        else
        begin
            region = REG_ZERO;
        end

        priority if (lam > SQRT_OUT_W'(cfg.fail))
        begin
            status = STAT_FAILED;
        end
        else if (lam > SQRT_OUT_W'(cfg.l1))
        begin
            status = STAT_CRITICAL;
        end
        else
        begin
            status = STAT_PRECRIT;
        end
    end

    assign push        = sv_reg[SQRT_LAT-1];
    assign item.neg_t  = s_out.side.neg_t;
    assign item.neg_n  = s_out.side.neg_n;
    assign item.mag_n  = s_out.side.mag_n;
    assign item.r_t    = s_out.r_t;
    assign item.r_n    = s_out.r_n;
    assign item.lam    = lam;
    assign item.region = region;
    assign item.status = status;

endmodule

// File: rtl/ctl_back.sv
// Back end: unit factors, peak stress scaling, tangential ratio, penetration
// penalty and saturation. Depends on ctl_pkg and ctl_div.
module ctl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  ctl_pkg::ctl_item_t item,
    input  ctl_pkg::ctl_cfg_t  cfg,
    output logic               result_valid,
    output ctl_pkg::ctl_out_t  result
);
    import ctl_pkg::*;

    localparam int FALL_W = 2 * ONSET_W;
    localparam int SP_W   = CFG_W + ONSET_W;
    localparam int PEN_W  = CFG_W + MAG_W;
    localparam int TN_W   = PEN_W - FRAC_BITS + 1;

    typedef struct packed {
        logic                       neg_t;
        logic                       neg_n;
        logic [WORD_BITS-1:0]       bn;
        logic [PEN_W-FRAC_BITS-1:0] pen;
        logic [SQRT_OUT_W-1:0]      lam;
        logic [1:0]                 status;
    } tail_t;

    function automatic logic [WORD_BITS-1:0] saturate(input logic [DIV_NUM_W-1:0] mag,
                                                      input logic neg);
        logic [WORD_BITS-1:0] lo;
        lo = mag[WORD_BITS-1:0];
        if (neg)
        begin
            return (mag >= (DIV_NUM_W'(1) << (WORD_BITS-1))) ?
                   (WORD_BITS'(1) << (WORD_BITS-1)) : (~lo + 1'b1);
        end
        return (mag > ((DIV_NUM_W'(1) << (WORD_BITS-1)) - 1'b1)) ?
               ((WORD_BITS'(1) << (WORD_BITS-1)) - 1'b1) : lo;
    endfunction

    logic                  e_valid_reg;
    ctl_item_t             e_item_reg;
    logic [FALL_W-1:0]     e_fall_t_reg;
    logic [FALL_W-1:0]     e_fall_n_reg;
    logic [FALL_W-1:0]     fall_den;
    logic [DIV_DEN_W-1:0]  e_fall_den_reg;
    logic [DIV_NUM_W-1:0]  num_t;
    logic [DIV_NUM_W-1:0]  num_n;
    logic [DIV_DEN_W-1:0]  den_m;
    logic [DIV_NUM_W-1:0]  quo_mt;
    logic [DIV_NUM_W-1:0]  quo_mn;
    logic [DIV_LAT-1:0]    mv_reg;
    ctl_item_t             mi_reg [DIV_LAT];
    logic [SP_W-1:0]       sp_t;
    logic [SP_W-1:0]       sp_n;
    logic                  g_valid_reg;
    ctl_item_t             g_item_reg;
    logic [WORD_BITS-1:0]  g_bt_reg;
    logic [WORD_BITS-1:0]  g_bn_reg;
    logic [PEN_W-1:0]      pen_full;
    logic                  h_valid_reg;
    tail_t                 h_tail_reg;
    logic [DIV_NUM_W-1:0]  h_prod_reg;
    logic [DIV_NUM_W-1:0]  quo_tt;
    logic [DIV_LAT-1:0]    tv_reg;
    tail_t                 ti_reg [DIV_LAT];
    tail_t                 t_out;
    logic [TN_W-1:0]       tn_mag;
    logic                  result_valid_reg;
    ctl_out_t              result_reg;

    assign fall_den = FALL_W'(item.lam[ONSET_W-1:0]) * FALL_W'(ONE_Q - cfg.l2);

    always_comb
    begin
        unique case (e_item_reg.region)
            REG_RISE:
            begin
                num_t = DIV_NUM_W'(e_item_reg.r_t) << FRAC_BITS;
                num_n = DIV_NUM_W'(e_item_reg.r_n) << FRAC_BITS;
                den_m = DIV_DEN_W'(cfg.l1);
            end
            REG_PLATEAU:
            begin
                num_t = DIV_NUM_W'(e_item_reg.r_t) << FRAC_BITS;
                num_n = DIV_NUM_W'(e_item_reg.r_n) << FRAC_BITS;
                den_m = DIV_DEN_W'(e_item_reg.lam);
            end
            REG_FALL:
            begin
                num_t = DIV_NUM_W'(e_fall_t_reg) << FRAC_BITS;
                num_n = DIV_NUM_W'(e_fall_n_reg) << FRAC_BITS;
                den_m = e_fall_den_reg;
            end
            default:
            begin
                num_t = '0;
                num_n = '0;
                den_m = DIV_DEN_W'(1);
            end
        endcase
    end

    ctl_div u_div_mt (
        .clk (clk),
        .num (num_t),
        .den (den_m),
        .quo (quo_mt)
    );

    ctl_div u_div_mn (
        .clk (clk),
        .num (num_n),
        .den (den_m),
        .quo (quo_mn)
    );

    assign sp_t     = SP_W'(cfg.peak_stress) * SP_W'(quo_mt[ONSET_W-1:0]);
    assign sp_n     = SP_W'(cfg.peak_stress) * SP_W'(quo_mn[ONSET_W-1:0]);
    assign pen_full = PEN_W'(cfg.stiff) * PEN_W'(g_item_reg.mag_n);

    ctl_div u_div_tt (
        .clk (clk),
        .num (h_prod_reg),
        .den (DIV_DEN_W'(cfg.dt)),
        .quo (quo_tt)
    );

    assign t_out  = ti_reg[DIV_LAT-1];
    assign tn_mag = TN_W'(t_out.bn) + TN_W'(t_out.pen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg      <= 1'b0;
            mv_reg           <= '0;
            g_valid_reg      <= 1'b0;
            h_valid_reg      <= 1'b0;
            tv_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg      <= take;
            mv_reg           <= {mv_reg[DIV_LAT-2:0], e_valid_reg};
            g_valid_reg      <= mv_reg[DIV_LAT-1];
            h_valid_reg      <= g_valid_reg;
            tv_reg           <= {tv_reg[DIV_LAT-2:0], h_valid_reg};
            result_valid_reg <= tv_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        // falling branch products; only meaningful when lambda is below one
        e_item_reg     <= item;
        e_fall_t_reg   <= FALL_W'(item.r_t[ONSET_W-1:0]) *
                          FALL_W'(ONE_Q - item.lam[ONSET_W-1:0]);
        e_fall_n_reg   <= FALL_W'(item.r_n[ONSET_W-1:0]) *
                          FALL_W'(ONE_Q - item.lam[ONSET_W-1:0]);
        e_fall_den_reg <= fall_den[DIV_DEN_W-1:0];

        mi_reg[0] <= e_item_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            mi_reg[k] <= mi_reg[k-1];
        end

        g_item_reg <= mi_reg[DIV_LAT-1];
        g_bt_reg   <= sp_t[SP_W-1 -: WORD_BITS];
        g_bn_reg   <= sp_n[SP_W-1 -: WORD_BITS];

        h_prod_reg        <= DIV_NUM_W'(g_bt_reg) * DIV_NUM_W'(cfg.dn);
        h_tail_reg.neg_t  <= g_item_reg.neg_t;
        h_tail_reg.neg_n  <= g_item_reg.neg_n;
        h_tail_reg.bn     <= g_bn_reg;
        h_tail_reg.pen    <= g_item_reg.neg_n ? pen_full[PEN_W-1:FRAC_BITS] : '0;
        h_tail_reg.lam    <= g_item_reg.lam;
        h_tail_reg.status <= g_item_reg.status;

        ti_reg[0] <= h_tail_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            ti_reg[k] <= ti_reg[k-1];
        end

        result_reg.traction_tangential <= saturate(quo_tt, t_out.neg_t);
        result_reg.traction_normal     <= t_out.neg_n ?
                                          saturate(DIV_NUM_W'(tn_mag), 1'b1) :
                                          saturate(DIV_NUM_W'(t_out.bn), 1'b0);
        result_reg.opening_lambda      <= t_out.lam[SQRT_OUT_W-1] ? '1 :
                                          t_out.lam[CFG_W-1:0];
        result_reg.surface_status      <= t_out.status;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/cohesive_traction_law.sv
// Top level of the trapezoidal cohesive traction law block: settings
// registers, front end, queue and back end. Depends on ctl_pkg and submodules.
//
// Takes one jump vector per clock once busy drops after reset.
// Each result appears in order, as a one-cycle result_valid strobe; there is
// no stall path, so the receiver must capture every strobe. The path runs
// through three 64-stage radix-2 divider pipelines (the two critical-opening
// scalings, the unit factors, and the opening ratio on the tangential term)
// and a 32-stage square root. Settings may only be written while no transfer
// is in flight; writes complete in the cycle given.
module cohesive_traction_law (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ctl_pkg::ctl_in_t              jump,
    output logic                          result_valid,
    output ctl_pkg::ctl_out_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ctl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ctl_pkg::*;

    logic [CFG_W-1:0]   peak_stress_reg;
    logic [CFG_W-1:0]   normal_crit_reg;
    logic [CFG_W-1:0]   tangent_crit_reg;
    logic [ONSET_W-1:0] peak_onset_reg;
    logic [ONSET_W-1:0] decline_onset_reg;
    logic [CFG_W-1:0]   failure_open_reg;
    logic [CFG_W-1:0]   pen_stiff_reg;
    logic               busy_reg;
    ctl_cfg_t           cfg;
    logic               accept;
    logic               push;
    ctl_item_t          push_item;
    logic               q_valid;
    ctl_item_t          q_item;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b1;
            peak_stress_reg   <= CFG_W'(65536);
            normal_crit_reg   <= CFG_W'(65536);
            tangent_crit_reg  <= CFG_W'(65536);
            peak_onset_reg    <= ONSET_W'(6554);
            decline_onset_reg <= ONSET_W'(58982);
            failure_open_reg  <= CFG_W'(65536);
            pen_stiff_reg     <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PEAK_STRESS:   peak_stress_reg   <= cfg_data[CFG_W-1:0];
                    CFG_NORMAL_CRIT:   normal_crit_reg   <= cfg_data[CFG_W-1:0];
                    CFG_TANGENT_CRIT:  tangent_crit_reg  <= cfg_data[CFG_W-1:0];
                    CFG_PEAK_ONSET:    peak_onset_reg    <= cfg_data[ONSET_W-1:0];
                    CFG_DECLINE_ONSET: decline_onset_reg <= cfg_data[ONSET_W-1:0];
                    CFG_FAILURE_OPEN:  failure_open_reg  <= cfg_data[CFG_W-1:0];
                    CFG_PEN_STIFFNESS: pen_stiff_reg     <= cfg_data[CFG_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.peak_stress = peak_stress_reg;
        cfg.dn          = (normal_crit_reg == '0) ? CFG_W'(1) : normal_crit_reg;
        cfg.dt          = (tangent_crit_reg == '0) ? CFG_W'(1) : tangent_crit_reg;
        cfg.l1          = peak_onset_reg;
        cfg.l2          = decline_onset_reg;
        cfg.fail        = (failure_open_reg < CFG_W'(ONE_Q)) ? CFG_W'(ONE_Q) :
                          failure_open_reg;
        cfg.stiff       = pen_stiff_reg;
    end

    ctl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .jump   (jump),
        .cfg    (cfg),
        .push   (push),
        .item   (push_item)
    );

    ctl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_item),
        .pop   (q_valid),
        .valid (q_valid),
        .dout  (q_item)
    );

    ctl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (q_valid),
        .item         (q_item),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: rtl/ctl_checker.sv
// Port-level checks for cohesive_traction_law, attached by bind.
// Depends on ctl_pkg for status codes and widths.
module ctl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          result_valid,
    input ctl_pkg::ctl_out_t             result,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);
    import ctl_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.surface_status == STAT_PRECRIT ||
                          result.surface_status == STAT_CRITICAL ||
                          result.surface_status == STAT_FAILED))
        else $error("undefined surface status");

    a_failed_lambda: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.surface_status == STAT_FAILED) |->
        (result.opening_lambda > CFG_W'(ONE_Q)))
        else $error("failed status with lambda at or below one");

    a_precrit_lambda: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.surface_status == STAT_PRECRIT) |->
        (result.opening_lambda[CFG_W-1:ONSET_W] == '0))
        else $error("precritical status beyond any peak onset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("settings write stalled");

    a_start_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("input taken in the first cycle after reset");

endmodule

bind cohesive_traction_law ctl_checker u_ctl_checker (.*);
